>>> hdl/scalar_kalman_filter_core_assert.svh
// assertion macros for the scalar kalman filter core
`ifndef SCALAR_KALMAN_FILTER_CORE_ASSERT_SVH
`define SCALAR_KALMAN_FILTER_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define SKF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define SKF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/skf_pkg.sv
package skf_pkg;

    localparam int X_W    = 32;
    localparam int COV_W  = 32;
    localparam int NOISE_W = 31;
    localparam int GAIN_W = 17;
    localparam int STAT_W = 2;
    localparam int PC_W   = 4;
    localparam int CNT_W  = 5;
    localparam int DIV_STEPS = 17;
    localparam int MUL_A_W = 34;
    localparam int MUL_B_W = 18;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    localparam logic [GAIN_W-1:0] GAIN_ONE = 17'h10000;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_ZERODEN  = 2'd1;
    localparam logic [STAT_W-1:0] ST_OVERFLOW = 2'd2;
    localparam logic [STAT_W-1:0] ST_SKIPPED  = 2'd3;

    // register indexes
    localparam logic [1:0] REG_PROCESS_NOISE      = 2'd0;
    localparam logic [1:0] REG_MEASUREMENT_NOISE  = 2'd1;
    localparam logic [1:0] REG_INITIAL_ESTIMATE   = 2'd2;
    localparam logic [1:0] REG_INITIAL_COVARIANCE = 2'd3;

    localparam logic [NOISE_W-1:0] RST_PROCESS_NOISE      = 31'd6554;
    localparam logic [NOISE_W-1:0] RST_MEASUREMENT_NOISE  = 31'd6554;
    localparam logic [X_W-1:0]     RST_INITIAL_ESTIMATE   = 32'd327680;
    localparam logic [NOISE_W-1:0] RST_INITIAL_COVARIANCE = 31'd6554;

    // datapath operations
    localparam logic [3:0] OP_NOP    = 4'd0;
    localparam logic [3:0] OP_ACCEPT = 4'd1;
    localparam logic [3:0] OP_LOAD   = 4'd2;
    localparam logic [3:0] OP_ADDQ   = 4'd3;
    localparam logic [3:0] OP_DEN    = 4'd4;
    localparam logic [3:0] OP_DIV    = 4'd5;
    localparam logic [3:0] OP_DIFF   = 4'd6;
    localparam logic [3:0] OP_MUL_X  = 4'd7;
    localparam logic [3:0] OP_ROUND  = 4'd8;
    localparam logic [3:0] OP_XUPD   = 4'd9;
    localparam logic [3:0] OP_MUL_P  = 4'd10;
    localparam logic [3:0] OP_PUPD   = 4'd11;
    localparam logic [3:0] OP_ZERO   = 4'd12;
    localparam logic [3:0] OP_SKIP   = 4'd13;
    localparam logic [3:0] OP_FINISH = 4'd14;

    // jump conditions
    localparam logic [2:0] C_NONE     = 3'd0;
    localparam logic [2:0] C_ALWAYS   = 3'd1;
    localparam logic [2:0] C_NO_REQ   = 3'd2;
    localparam logic [2:0] C_HALT     = 3'd3;
    localparam logic [2:0] C_DEN_ZERO = 3'd4;
    localparam logic [2:0] C_DIV_MORE = 3'd5;
    localparam logic [2:0] C_OUT_BUSY = 3'd6;

    // program addresses
    localparam logic [PC_W-1:0] A_WAIT   = 4'd0;
    localparam logic [PC_W-1:0] A_LOAD   = 4'd1;
    localparam logic [PC_W-1:0] A_ADDQ   = 4'd2;
    localparam logic [PC_W-1:0] A_DEN    = 4'd3;
    localparam logic [PC_W-1:0] A_ZCHK   = 4'd4;
    localparam logic [PC_W-1:0] A_DIV    = 4'd5;
    localparam logic [PC_W-1:0] A_DIFF   = 4'd6;
    localparam logic [PC_W-1:0] A_MUL_X  = 4'd7;
    localparam logic [PC_W-1:0] A_ROUND  = 4'd8;
    localparam logic [PC_W-1:0] A_XUPD   = 4'd9;
    localparam logic [PC_W-1:0] A_MUL_P  = 4'd10;
    localparam logic [PC_W-1:0] A_PUPD   = 4'd11;
    localparam logic [PC_W-1:0] A_ZERO   = 4'd12;
    localparam logic [PC_W-1:0] A_SKIP   = 4'd13;
    localparam logic [PC_W-1:0] A_FINISH = 4'd14;
    localparam logic [PC_W-1:0] A_RET    = 4'd15;

    typedef struct packed {
        logic [3:0]      op;
        logic [2:0]      cond;
        logic [PC_W-1:0] target;
    } skf_ctl_t;

    typedef struct packed {
        logic no_req;
        logic halt;
        logic den_zero;
        logic div_more;
        logic out_busy;
    } skf_flags_t;

    typedef struct packed {
        logic halt;
        logic den_zero;
        logic div_more;
    } skf_dp_stat_t;

    function automatic skf_ctl_t skf_ucode(input logic [PC_W-1:0] addr);
        skf_ctl_t w;
        unique case (addr)
            A_WAIT:   w = '{OP_ACCEPT, C_NO_REQ,   A_WAIT};
            A_LOAD:   w = '{OP_LOAD,   C_NONE,     A_WAIT};
            A_ADDQ:   w = '{OP_ADDQ,   C_HALT,     A_SKIP};
            A_DEN:    w = '{OP_DEN,    C_NONE,     A_WAIT};
            A_ZCHK:   w = '{OP_NOP,    C_DEN_ZERO, A_ZERO};
            A_DIV:    w = '{OP_DIV,    C_DIV_MORE, A_DIV};
            A_DIFF:   w = '{OP_DIFF,   C_NONE,     A_WAIT};
            A_MUL_X:  w = '{OP_MUL_X,  C_NONE,     A_WAIT};
            A_ROUND:  w = '{OP_ROUND,  C_NONE,     A_WAIT};
            A_XUPD:   w = '{OP_XUPD,   C_NONE,     A_WAIT};
            A_MUL_P:  w = '{OP_MUL_P,  C_NONE,     A_WAIT};
            A_PUPD:   w = '{OP_PUPD,   C_ALWAYS,   A_FINISH};
            A_ZERO:   w = '{OP_ZERO,   C_ALWAYS,   A_FINISH};
            A_SKIP:   w = '{OP_SKIP,   C_NONE,     A_WAIT};
            A_FINISH: w = '{OP_FINISH, C_OUT_BUSY, A_FINISH};
            A_RET:    w = '{OP_NOP,    C_ALWAYS,   A_WAIT};
            default:  w = '{OP_NOP,    C_ALWAYS,   A_WAIT};
        endcase
        return w;
    endfunction

endpackage

>>> hdl/skf_if.sv
interface skf_sample_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] measurement;
    logic               restart;
    logic               last_sample;

    modport source (output valid, output measurement, output restart, output last_sample,
                    input ready);
    modport sink (input valid, input measurement, input restart, input last_sample,
                  output ready);
endinterface

interface skf_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] estimate;
    logic [16:0]        gain;
    logic [1:0]         status;

    modport source (output valid, output estimate, output gain, output status,
                    input ready);
    modport sink (input valid, input estimate, input gain, input status,
                  output ready);
endinterface

>>> hdl/scalar_kalman_filter_core.sv
// channel   dir  handshake     payload
// samples   in   valid/ready   measurement[31:0] restart last_sample
// results   out  valid/ready   estimate[31:0] gain[16:0] status[1:0]
// cfg       in   cfg_we        cfg_index[1:0] cfg_data[31:0]
//
// a normal sample runs a 17-step restoring divide for the gain plus two passes
// through the multiplier; skipped and zero-denominator samples bypass both the
// divide and the multiplier
// one sample in flight; the result register lets the next request in while a
// result waits, a held result stalls only the final step
// reset loads the estimate and covariance from the register reset values
module scalar_kalman_filter_core
    import skf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    skf_sample_if.sink  samples,
    skf_result_if.source results,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    logic [NOISE_W-1:0] q_reg;
    logic [NOISE_W-1:0] r_reg;
    logic [X_W-1:0]     x_init_reg;
    logic [NOISE_W-1:0] p_init_reg;

    logic               out_valid_reg;
    logic [X_W-1:0]     estimate_reg;
    logic [GAIN_W-1:0]  gain_reg;
    logic [STAT_W-1:0]  status_reg;

    skf_ctl_t     ctl;
    skf_flags_t   flags;
    skf_dp_stat_t dp_stat;
    logic         in_take;
    logic         out_free;
    logic [X_W-1:0]    dp_x;
    logic [GAIN_W-1:0] dp_k;
    logic [STAT_W-1:0] dp_status;

    assign samples.ready = (ctl.op == OP_ACCEPT);
    assign in_take  = samples.valid && samples.ready;
    assign out_free = !out_valid_reg || results.ready;

    assign flags.no_req   = !samples.valid;
    assign flags.halt     = dp_stat.halt;
    assign flags.den_zero = dp_stat.den_zero;
    assign flags.div_more = dp_stat.div_more;
    assign flags.out_busy = !out_free;

    skf_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctl   (ctl)
    );

    skf_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .op         (ctl.op),
        .in_take    (in_take),
        .out_free   (out_free),
        .z_in       (samples.measurement),
        .restart_in (samples.restart),
        .last_in    (samples.last_sample),
        .q_cfg      (q_reg),
        .r_cfg      (r_reg),
        .x_init_cfg (x_init_reg),
        .p_init_cfg (p_init_reg),
        .x_out      (dp_x),
        .k_out      (dp_k),
        .status_out (dp_status),
        .stat       (dp_stat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_reg      <= RST_PROCESS_NOISE;
            r_reg      <= RST_MEASUREMENT_NOISE;
            x_init_reg <= RST_INITIAL_ESTIMATE;
            p_init_reg <= RST_INITIAL_COVARIANCE;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PROCESS_NOISE:      q_reg      <= cfg_data[NOISE_W-1:0];
                REG_MEASUREMENT_NOISE:  r_reg      <= cfg_data[NOISE_W-1:0];
                REG_INITIAL_ESTIMATE:   x_init_reg <= cfg_data;
                REG_INITIAL_COVARIANCE: p_init_reg <= cfg_data[NOISE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl.op == OP_FINISH && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.op == OP_FINISH && out_free)
        begin
            estimate_reg <= dp_x;
            gain_reg     <= dp_k;
            status_reg   <= dp_status;
        end
    end

    assign results.valid    = out_valid_reg;
    assign results.estimate = estimate_reg;
    assign results.gain     = gain_reg;
    assign results.status   = status_reg;

`include "scalar_kalman_filter_core_assert.svh"

    `SKF_ASSERT_NEXT(a_one_in_flight, samples.valid && samples.ready, !samples.ready, "request taken while a sample is in flight")
    `SKF_ASSERT_NOW(a_gain_range, ctl.op == OP_PUPD, dp_k <= GAIN_ONE, "gain above one after divide")
    `SKF_ASSERT_NOW(a_err_no_gain, results.valid && (results.status == ST_ZERODEN || results.status == ST_SKIPPED), results.gain == '0, "nonzero gain on error result")

endmodule

>>> hdl/skf_seq.sv
module skf_seq
    import skf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  skf_flags_t flags,
    output skf_ctl_t   ctl
);

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    logic            take;

    assign ctl = skf_ucode(pc_reg);

    always_comb
    begin
        unique case (ctl.cond)
            C_NONE:     take = 1'b0;
            C_ALWAYS:   take = 1'b1;
            C_NO_REQ:   take = flags.no_req;
            C_HALT:     take = flags.halt;
            C_DEN_ZERO: take = flags.den_zero;
            C_DIV_MORE: take = flags.div_more;
            C_OUT_BUSY: take = flags.out_busy;
            default:    take = 1'b0;
        endcase
        pc_next = take ? ctl.target : pc_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= A_WAIT;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

>>> hdl/skf_datapath.sv
module skf_datapath
    import skf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [3:0]           op,
    input  logic                 in_take,
    input  logic                 out_free,
    input  logic signed [X_W-1:0] z_in,
    input  logic                 restart_in,
    input  logic                 last_in,
    input  logic [NOISE_W-1:0]   q_cfg,
    input  logic [NOISE_W-1:0]   r_cfg,
    input  logic [X_W-1:0]       x_init_cfg,
    input  logic [NOISE_W-1:0]   p_init_cfg,
    output logic [X_W-1:0]       x_out,
    output logic [GAIN_W-1:0]    k_out,
    output logic [STAT_W-1:0]    status_out,
    output skf_dp_stat_t         stat
);

    // state
    logic [X_W-1:0]   x_reg;
    logic [COV_W-1:0] p_reg;
    logic             halt_reg;
    logic [CNT_W-1:0] cnt_reg;

    // working registers
    logic [X_W-1:0]           z_reg;
    logic                     restart_reg;
    logic                     last_reg;
    logic [COV_W-1:0]         p1_reg;
    logic [COV_W:0]           den_reg;
    logic [COV_W+1:0]         rem_reg;
    logic [GAIN_W-1:0]        k_reg;
    logic signed [X_W:0]      diff_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [X_W+2:0]    dx_reg;
    logic [STAT_W-1:0]        status_reg;
    logic                     err_reg;

    logic [COV_W:0]           p_sum;
    logic [COV_W+1:0]         trial;
    logic                     ge;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0] rnd;
    logic signed [X_W+2:0]    x_sum;
    logic [X_W-1:0]           x_sat;
    logic [GAIN_W-1:0]        k_comp;

    assign p_sum  = {1'b0, p_reg} + {2'b00, q_cfg};
    // the first division step compares p1 itself, later steps shift the remainder
    assign trial  = (cnt_reg == '0) ? rem_reg : {rem_reg[COV_W:0], 1'b0};
    assign ge     = trial >= {1'b0, den_reg};
    assign k_comp = GAIN_ONE - k_reg;
    assign rnd    = prod_reg + PROD_W'(32768);
    assign x_sum  = {{3{x_reg[X_W-1]}}, x_reg} + dx_reg;

    always_comb
    begin
        if (op == OP_MUL_P)
        begin
            mul_a = {2'b00, p1_reg};
            mul_b = {1'b0, k_comp};
        end
        else
        begin
            mul_a = {diff_reg[X_W], diff_reg};
            mul_b = {1'b0, k_reg};
        end
        // clamp to the signed 32-bit range
        if (x_sum[X_W+2:X_W-1] == '0 || x_sum[X_W+2:X_W-1] == '1)
            x_sat = x_sum[X_W-1:0];
        else if (x_sum[X_W+2])
            x_sat = {1'b1, {(X_W-1){1'b0}}};
        else
            x_sat = {1'b0, {(X_W-1){1'b1}}};
    end

    assign x_out      = x_reg;
    assign k_out      = k_reg;
    assign status_out = status_reg;
    assign stat.halt     = halt_reg;
    assign stat.den_zero = (den_reg == '0);
    assign stat.div_more = (cnt_reg != CNT_W'(DIV_STEPS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg    <= RST_INITIAL_ESTIMATE;
            p_reg    <= {1'b0, RST_INITIAL_COVARIANCE};
            halt_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            unique case (op)
                OP_LOAD:
                begin
                    if (restart_reg)
                    begin
                        x_reg    <= x_init_cfg;
                        p_reg    <= {1'b0, p_init_cfg};
                        halt_reg <= 1'b0;
                    end
                end
                OP_DEN:  cnt_reg <= '0;
                OP_DIV:  cnt_reg <= cnt_reg + 1'b1;
                OP_XUPD: x_reg <= x_sat;
                OP_PUPD: p_reg <= rnd[COV_W+15:16];
                OP_FINISH:
                begin
                    if (out_free)
                        halt_reg <= last_reg ? 1'b0 : (halt_reg | err_reg);
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (op)
            OP_ACCEPT:
            begin
                if (in_take)
                begin
                    z_reg       <= z_in;
                    restart_reg <= restart_in;
                    last_reg    <= last_in;
                end
            end
            OP_ADDQ:
            begin
                p1_reg     <= p_sum[COV_W] ? '1 : p_sum[COV_W-1:0];
                status_reg <= p_sum[COV_W] ? ST_OVERFLOW : ST_OK;
                err_reg    <= p_sum[COV_W];
            end
            OP_DEN:
            begin
                den_reg <= {1'b0, p1_reg} + {2'b00, r_cfg};
                rem_reg <= {2'b00, p1_reg};
                k_reg   <= '0;
            end
            OP_DIV:
            begin
                rem_reg <= ge ? trial - {1'b0, den_reg} : trial;
                k_reg   <= {k_reg[GAIN_W-2:0], ge};
            end
            OP_DIFF:  diff_reg <= {z_reg[X_W-1], z_reg} - {x_reg[X_W-1], x_reg};
            OP_MUL_X: prod_reg <= mul_a * mul_b;
            OP_ROUND: dx_reg <= rnd[X_W+18:16];
            OP_MUL_P: prod_reg <= mul_a * mul_b;
            OP_ZERO:
            begin
                status_reg <= ST_ZERODEN;
                k_reg      <= '0;
                err_reg    <= 1'b1;
            end
            OP_SKIP:
            begin
                status_reg <= ST_SKIPPED;
                k_reg      <= '0;
                err_reg    <= 1'b0;
            end
            default: ;
        endcase
    end

endmodule

>>> dv/tb_top.sv
module tb_top;
    import skf_pkg::*;

    localparam int CYCLE_LIMIT   = 600000;
    localparam int MAX_IDLE      = 8;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES  = 40;
    localparam int REPORT_LIMIT  = 10;
    localparam longint X_MAX     = 64'sh7FFF_FFFF;
    localparam longint X_MIN     = -X_MAX - 1;

    typedef struct packed {
        logic [31:0] estimate;
        logic [16:0] gain;
        logic [1:0]  status;
    } kalman_result_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;

    skf_sample_if samples_if();
    skf_result_if results_if();

    scalar_kalman_filter_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .samples   (samples_if),
        .results   (results_if),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // filter state and register copies kept alongside the block
    logic [31:0] model_estimate;
    logic [31:0] model_covariance;
    logic        model_halted;
    logic [30:0] noise_q;
    logic [30:0] noise_r;
    logic [31:0] start_estimate;
    logic [30:0] start_covariance;

    kalman_result_t pending_results[$];

    bit send_idle_en = 1'b1;
    bit recv_idle_en = 1'b1;
    int result_hold  = 0;
    int fail_count   = 0;
    int result_count = 0;
    int cycle_count  = 0;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("run stopped at cycle limit, %0d results outstanding",
                     pending_results.size());
            $display("FAIL");
            $finish;
        end
    end

    // one filter step: predict, gain, update estimate and covariance
    task automatic predict_kalman_update(input logic [31:0] z, input logic rs,
                                         input logic ls);
        kalman_result_t res;
        logic [32:0]    p1;
        logic [33:0]    den;
        logic [63:0]    quot;
        logic [16:0]    k;
        logic [63:0]    pn_full;
        longint         diff;
        longint         prod;
        longint         dx;
        longint         xn;
        res.gain = '0;
        if (rs)
        begin
            model_estimate   = start_estimate;
            model_covariance = {1'b0, start_covariance};
            model_halted     = 1'b0;
        end
        if (model_halted)
        begin
            res.status = ST_SKIPPED;
        end
        else
        begin
            res.status = ST_OK;
            p1 = {1'b0, model_covariance} + {2'b0, noise_q};
            if (p1 > 33'h0_FFFF_FFFF)
            begin
                p1 = 33'h0_FFFF_FFFF;
                res.status = ST_OVERFLOW;
            end
            den = {1'b0, p1} + {3'b0, noise_r};
            if (den == '0)
            begin
                res.status = ST_ZERODEN;
                model_halted = 1'b1;
            end
            else
            begin
                quot = {16'b0, p1[31:0], 16'b0} / {30'b0, den};
                k    = quot[16:0];
                diff = longint'($signed(z)) - longint'($signed(model_estimate));
                prod = longint'({47'b0, k}) * diff;
                // floor of (prod + half) / 2^16, ties go up
                dx = (prod + 32768) >>> 16;
                xn = longint'($signed(model_estimate)) + dx;
                if (xn > X_MAX)
                    xn = X_MAX;
                if (xn < X_MIN)
                    xn = X_MIN;
                pn_full = (({47'b0, GAIN_ONE} - {47'b0, k}) * {31'b0, p1}
                           + 64'd32768) >> 16;
                model_estimate   = xn[31:0];
                model_covariance = pn_full[31:0];
                res.gain = k;
                if (res.status == ST_OVERFLOW)
                    model_halted = 1'b1;
            end
        end
        if (ls)
            model_halted = 1'b0;
        res.estimate = model_estimate;
        pending_results.push_back(res);
    endtask

    task automatic send_sample(input logic [31:0] z, input logic rs, input logic ls);
        int gap;
        gap = send_idle_en ? $urandom_range(0, MAX_IDLE) : 0;
        if (gap > 0)
        begin
            samples_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        samples_if.valid       <= 1'b1;
        samples_if.measurement <= z;
        samples_if.restart     <= rs;
        samples_if.last_sample <= ls;
        do
            @(posedge clk);
        while (!samples_if.ready);
        predict_kalman_update(z, rs, ls);
    endtask

    task wait_idle;
        samples_if.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_filter_config(input logic [31:0] q, input logic [31:0] r,
                                     input logic [31:0] x0, input logic [31:0] p0);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= REG_PROCESS_NOISE;
        cfg_data  <= q;
        @(posedge clk);
        cfg_index <= REG_MEASUREMENT_NOISE;
        cfg_data  <= r;
        @(posedge clk);
        cfg_index <= REG_INITIAL_ESTIMATE;
        cfg_data  <= x0;
        @(posedge clk);
        cfg_index <= REG_INITIAL_COVARIANCE;
        cfg_data  <= p0;
        @(posedge clk);
        cfg_we <= 1'b0;
        noise_q          = q[30:0];
        noise_r          = r[30:0];
        start_estimate   = x0;
        start_covariance = p0[30:0];
    endtask

    function automatic logic [31:0] pick_noise_value();
        logic [31:0] v;
        case ($urandom_range(0, 4))
            0:       v = 32'h0;
            1:       v = 32'h7FFF_FFFF;
            2:       v = $urandom_range(0, 131072);
            3:       v = $urandom_range(4096, 1 << 22);
            default: v = $urandom;
        endcase
        // top bit is dropped by the 31-bit registers
        v[31] = 1'($urandom_range(0, 1));
        return v;
    endfunction

    function automatic logic [31:0] pick_initial_estimate();
        logic [31:0] v;
        case ($urandom_range(0, 4))
            0:       v = 32'h8000_0000;
            1:       v = 32'h7FFF_FFFF;
            2:       v = 32'($urandom_range(0, 1 << 22)) - 32'(1 << 21);
            default: v = $urandom;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] pick_measurement();
        logic [31:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = model_estimate + 32'($urandom_range(0, 1 << 20)) - 32'(1 << 19);
            4, 5, 6:    v = $urandom;
            7:          v = 32'h7FFF_FFFF;
            8:          v = 32'h8000_0000;
            default:    v = 32'($urandom_range(0, 1 << 18)) - 32'(1 << 17);
        endcase
        return v;
    endfunction

    // result side: random stalls, optional long hold, compare in order
    initial
    begin : result_sink
        kalman_result_t want;
        int             gap;
        results_if.ready <= 1'b0;
        @(posedge clk);
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            if (result_hold > 0)
            begin
                results_if.ready <= 1'b0;
                repeat (result_hold) @(posedge clk);
                result_hold = 0;
            end
            gap = recv_idle_en ? $urandom_range(0, MAX_IDLE) : 0;
            if (gap > 0)
            begin
                results_if.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            results_if.ready <= 1'b1;
            do
                @(posedge clk);
            while (!results_if.valid);
            if (pending_results.size() == 0)
            begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT)
                    $display("result %0d unexpected: estimate %h gain %h status %0d",
                             result_count, results_if.estimate, results_if.gain,
                             results_if.status);
            end
            else
            begin
                want = pending_results.pop_front();
                if (results_if.estimate !== want.estimate || results_if.gain !== want.gain
                    || results_if.status !== want.status)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display({"result %0d mismatch: estimate exp %h got %h, ",
                                  "gain exp %h got %h, status exp %0d got %0d"},
                                 result_count, want.estimate, results_if.estimate,
                                 want.gain, results_if.gain, want.status,
                                 results_if.status);
                end
            end
            result_count++;
        end
    end

    task test_reset_state;
        // no restart: state comes from the register reset values
        send_sample(32'h7FFF_FFFF, 1'b0, 1'b0);
        send_sample(32'h8000_0000, 1'b0, 1'b0);
        send_sample(32'h0000_0000, 1'b0, 1'b0);
        send_sample(32'hFFFF_FFFF, 1'b0, 1'b1);
    endtask

    task test_gain_extremes;
        // no measurement noise: full gain, estimate jumps across the range
        set_filter_config(32'd1, 32'd0, 32'h8000_0000, 32'h7FFF_FFFF);
        send_sample(32'h7FFF_FFFF, 1'b1, 1'b0);
        send_sample(32'h8000_0000, 1'b0, 1'b0);
        // huge measurement noise: gain rounds down to zero
        set_filter_config(32'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd1);
        send_sample(32'h8000_0000, 1'b1, 1'b1);
        // half gain with a one-lsb error: rounding ties
        set_filter_config(32'd0, 32'h0001_0000, 32'd0, 32'h0001_0000);
        send_sample(32'h0000_0001, 1'b1, 1'b0);
        send_sample(32'hFFFF_FFFF, 1'b1, 1'b1);
    endtask

    task test_zero_denominator;
        set_filter_config(32'd0, 32'd0, 32'h1234_5678, 32'd0);
        send_sample($urandom, 1'b1, 1'b0);
        send_sample($urandom, 1'b0, 1'b0);
        // skipped, but the last flag releases the halt
        send_sample($urandom, 1'b0, 1'b1);
        send_sample($urandom, 1'b0, 1'b0);
        // error raised and released by the same sample
        send_sample($urandom, 1'b1, 1'b1);
        send_sample($urandom, 1'b0, 1'b0);
    endtask

    task test_covariance_ceiling;
        // largest noise and covariance the registers hold, bit 31 set and dropped
        set_filter_config(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
        send_sample(32'h8000_0000, 1'b1, 1'b0);
        send_sample(32'h7FFF_FFFF, 1'b0, 1'b0);
        send_sample(32'h8000_0000, 1'b0, 1'b0);
        send_sample(32'h7FFF_FFFF, 1'b0, 1'b0);
        send_sample(32'h0000_0000, 1'b0, 1'b1);
    endtask

    task test_backpressure;
        set_filter_config(32'h0001_0000, 32'h0004_0000, 32'd0, 32'h0001_0000);
        send_idle_en = 1'b0;
        result_hold  = 400;
        for (int i = 0; i < 30; i++)
            send_sample(pick_measurement(), i == 0, i == 29);
        send_idle_en = 1'b1;
        // sender holds back until every result is in
        wait_idle();
        for (int i = 0; i < 10; i++)
            send_sample(pick_measurement(), 1'b0, i == 9);
    endtask

    task automatic test_random_runs(input int target);
        int          sent;
        int          phase;
        int          phase_left;
        int          run_len;
        logic [31:0] q_val;
        logic [31:0] r_val;
        sent  = 0;
        phase = 0;
        while (sent < target)
        begin
            phase++;
            q_val = pick_noise_value();
            r_val = pick_noise_value();
            // no noise at all: covariance collapses, then the denominator hits zero
            if (phase % 6 == 0)
            begin
                q_val[30:0] = '0;
                r_val[30:0] = '0;
            end
            set_filter_config(q_val, r_val, pick_initial_estimate(), pick_noise_value());
            send_idle_en = ($urandom_range(0, 3) != 0);
            recv_idle_en = ($urandom_range(0, 3) != 0);
            phase_left   = $urandom_range(20, 120);
            while (phase_left > 0)
            begin
                if ($urandom_range(0, 99) < 85)
                begin
                    run_len = $urandom_range(1, 24);
                    if (run_len > phase_left)
                        run_len = phase_left;
                    for (int i = 0; i < run_len; i++)
                        send_sample(pick_measurement(), i == 0, i == run_len - 1);
                    phase_left -= run_len;
                    sent       += run_len;
                end
                else
                begin
                    send_sample(pick_measurement(), $urandom_range(0, 3) == 0,
                                $urandom_range(0, 3) == 0);
                    phase_left--;
                    sent++;
                end
            end
        end
    endtask

    initial
    begin
        rst_n                  <= 1'b0;
        cfg_we                 <= 1'b0;
        cfg_index              <= REG_PROCESS_NOISE;
        cfg_data               <= '0;
        samples_if.valid       <= 1'b0;
        samples_if.measurement <= '0;
        samples_if.restart     <= 1'b0;
        samples_if.last_sample <= 1'b0;
        noise_q          = RST_PROCESS_NOISE;
        noise_r          = RST_MEASUREMENT_NOISE;
        start_estimate   = RST_INITIAL_ESTIMATE;
        start_covariance = RST_INITIAL_COVARIANCE;
        model_estimate   = RST_INITIAL_ESTIMATE;
        model_covariance = {1'b0, RST_INITIAL_COVARIANCE};
        model_halted     = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_gain_extremes();
        test_zero_denominator();
        test_covariance_ceiling();
        test_backpressure();
        test_random_runs(1400);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

>>> sim.f
+incdir+hdl
hdl/skf_pkg.sv
hdl/skf_if.sv
hdl/skf_seq.sv
hdl/skf_datapath.sv
hdl/scalar_kalman_filter_core.sv
dv/tb_top.sv
